// File: rtl/core/scc_pkg.sv
// Shared constants, types and state encoding for the strongly connected components block.
package scc_pkg;

	localparam int MaxNodes = 64;
	localparam int MaxEdges = 256;
	localparam int NodeW = $clog2(MaxNodes);
	localparam int EdgeW = $clog2(MaxEdges);
	localparam int CountW = NodeW + 1;
	localparam int EcntW = EdgeW + 1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLR,
		ST_P1_ROOT,
		ST_SCAN,
		ST_POP,
		ST_P2_ROOT,
		ST_P2_WAIT,
		ST_OUT_RD,
		ST_OUT
	} scc_state_t;

	typedef struct packed {
		logic store_edge;
		logic clr_start;
		logic clr_step;
		logic root_start;
		logic scan_step;
		logic pop_step;
		logic p2_pop;
		logic p2_start;
		logic out_start;
		logic out_rd;
		logic out_next;
		logic run_done;
		logic pass2;
	} scc_cmd_t;

	typedef struct packed {
		logic root_done;
		logic root_visited;
		logic scan_done;
		logic stack_empty;
		logic fin_empty;
		logic p2_take;
		logic out_last;
	} scc_sts_t;

endpackage

// File: rtl/core/scc_datapath.sv
// Datapath: edge memories, visited marks, search and finish stacks, labels and result register.
module scc_datapath import scc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scc_cmd_t             cmd,
	output scc_sts_t             sts,
	input  logic [CountW-1:0]    n_eff,
	input  logic                 in_valid,
	input  logic [NodeW-1:0]     in_from,
	input  logic [NodeW-1:0]     in_to,
	output logic [NodeW-1:0]     res_node,
	output logic [CountW-1:0]    res_id,
	output logic [CountW-1:0]    res_total,
	output logic                 res_ovf,
	output logic                 res_last
);

	logic [NodeW-1:0]  src_mem [MaxEdges];
	logic [NodeW-1:0]  dst_mem [MaxEdges];
	logic [NodeW-1:0]  fin_mem [MaxNodes];
	logic [NodeW-1:0]  stk_node [MaxNodes];
	logic [EcntW-1:0]  stk_cur [MaxNodes];
	logic [CountW-1:0] lab_mem [MaxNodes];
	logic [MaxNodes-1:0] vis_q;
	logic [EcntW-1:0]  etot_q;
	logic              ovf_q;
	logic [CountW-1:0] top_q;
	logic [CountW-1:0] ftop_q;
	logic [CountW-1:0] root_q;
	logic [CountW-1:0] total_q;
	logic [CountW-1:0] oidx_q;
	logic [NodeW-1:0]  node_q;
	logic [EcntW-1:0]  cur_q;
	logic [NodeW-1:0]  s_q;
	logic [NodeW-1:0]  d_q;
	logic              ed_ok_q;
	logic              scan_rd_q;
	logic [NodeW-1:0]  fin_rd_q;
	logic [NodeW-1:0]  stk_node_rd_q;
	logic [EcntW-1:0]  stk_cur_rd_q;
	logic [NodeW-1:0]  here;
	logic [NodeW-1:0]  there;
	logic              hit;
	logic [NodeW-1:0]  root6;

	assign root6 = root_q[NodeW-1:0];
	assign here  = cmd.pass2 ? d_q : s_q;
	assign there = cmd.pass2 ? s_q : d_q;
	assign hit   = scan_rd_q && ed_ok_q && here == node_q && !vis_q[there];

	always_comb begin
		sts = '0;
		sts.root_done    = root_q >= n_eff;
		sts.root_visited = vis_q[root6];
		sts.scan_done    = (cur_q >= etot_q) && !hit;
		sts.stack_empty  = top_q == '0;
		sts.fin_empty    = ftop_q == '0;
		sts.p2_take      = !vis_q[fin_rd_q];
		sts.out_last     = oidx_q + 1'b1 == n_eff;
	end

	always_ff @(posedge clk) begin
		if (cmd.store_edge && in_valid && etot_q < EcntW'(MaxEdges)
				&& {1'b0, in_from} < n_eff && {1'b0, in_to} < n_eff) begin
			src_mem[etot_q[EdgeW-1:0]] <= in_from;
			dst_mem[etot_q[EdgeW-1:0]] <= in_to;
		end
		s_q <= src_mem[cur_q[EdgeW-1:0]];
		d_q <= dst_mem[cur_q[EdgeW-1:0]];
		ed_ok_q <= {1'b0, src_mem[cur_q[EdgeW-1:0]]} < n_eff
			&& {1'b0, dst_mem[cur_q[EdgeW-1:0]]} < n_eff && cur_q < etot_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.root_start)
			stk_node[0] <= root6;
		else if (cmd.p2_start)
			stk_node[0] <= fin_rd_q;
		else if (cmd.scan_step && hit && top_q < CountW'(MaxNodes))
			stk_node[top_q[NodeW-1:0]] <= there;
		if (cmd.scan_step && hit)
			stk_cur[NodeW'(top_q - 1'b1)] <= cur_q;
		if (cmd.p2_start)
			lab_mem[fin_rd_q] <= total_q + 1'b1;
		else if (cmd.scan_step && hit && cmd.pass2)
			lab_mem[there] <= total_q;
		if (cmd.pop_step && !cmd.pass2 && ftop_q < CountW'(MaxNodes))
			fin_mem[ftop_q[NodeW-1:0]] <= node_q;
		fin_rd_q <= fin_mem[NodeW'(ftop_q - 1'b1)];
		stk_node_rd_q <= stk_node[NodeW'(top_q - 2'd2)];
		stk_cur_rd_q <= stk_cur[NodeW'(top_q - 2'd2)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etot_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.run_done) begin
			etot_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.store_edge && in_valid) begin
			if (etot_q >= EcntW'(MaxEdges) || {1'b0, in_from} >= n_eff
					|| {1'b0, in_to} >= n_eff)
				ovf_q <= 1'b1;
			else
				etot_q <= etot_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q <= '0;
			top_q <= '0;
			ftop_q <= '0;
			root_q <= '0;
			total_q <= '0;
			cur_q <= '0;
			node_q <= '0;
			oidx_q <= '0;
			scan_rd_q <= 1'b0;
		end else begin
			scan_rd_q <= cmd.scan_step && !hit && cur_q < etot_q;
			if (cmd.clr_start) begin
				vis_q <= '0;
				root_q <= '0;
				top_q <= '0;
				if (!cmd.pass2) begin
					ftop_q <= '0;
					total_q <= '0;
				end
			end else if (cmd.clr_step) begin
				root_q <= root_q + 1'b1;
			end else if (cmd.root_start) begin
				vis_q[root6] <= 1'b1;
				node_q <= root6;
				cur_q <= '0;
				top_q <= CountW'(1);
			end else if (cmd.p2_pop) begin
				ftop_q <= ftop_q - 1'b1;
			end else if (cmd.p2_start) begin
				vis_q[fin_rd_q] <= 1'b1;
				total_q <= total_q + 1'b1;
				node_q <= fin_rd_q;
				cur_q <= '0;
				top_q <= CountW'(1);
				ftop_q <= ftop_q - 1'b1;
			end else if (cmd.scan_step) begin
				if (hit) begin
					vis_q[there] <= 1'b1;
					if (top_q < CountW'(MaxNodes)) begin
						top_q <= top_q + 1'b1;
						node_q <= there;
						cur_q <= '0;
					end
				end else if (cur_q < etot_q) begin
					cur_q <= cur_q + 1'b1;
				end
			end else if (cmd.pop_step) begin
				if (!cmd.pass2 && ftop_q < CountW'(MaxNodes))
					ftop_q <= ftop_q + 1'b1;
				top_q <= top_q - 1'b1;
				if (top_q > CountW'(1)) begin
					node_q <= stk_node_rd_q;
					cur_q <= stk_cur_rd_q;
				end
			end else if (cmd.out_start) begin
				oidx_q <= '0;
			end else if (cmd.out_next) begin
				oidx_q <= oidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_rd) begin
			res_node <= oidx_q[NodeW-1:0];
			res_id <= lab_mem[oidx_q[NodeW-1:0]];
			res_total <= total_q;
			res_ovf <= ovf_q;
			res_last <= oidx_q + 1'b1 == n_eff;
		end
	end

	property p_top_bound;
		@(posedge clk) disable iff (!arst_n) top_q <= CountW'(MaxNodes);
	endproperty
	a_top_bound: assert property (p_top_bound) else $error("search stack overrun");

	property p_ftop_bound;
		@(posedge clk) disable iff (!arst_n) ftop_q <= CountW'(MaxNodes);
	endproperty
	a_ftop_bound: assert property (p_ftop_bound) else $error("finish stack overrun");

	property p_etot_bound;
		@(posedge clk) disable iff (!arst_n) etot_q <= EcntW'(MaxEdges);
	endproperty
	a_etot_bound: assert property (p_etot_bound) else $error("edge count overrun");

endmodule

// File: rtl/core/scc_ctrl.sv
// Controller state machine sequencing load, both search passes and result output.
module scc_ctrl import scc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     in_last,
	input  logic     out_free,
	input  logic     out_fire,
	input  scc_sts_t sts,
	output scc_cmd_t cmd,
	output logic     in_rdy,
	output logic     busy,
	output logic     res_load
);

	scc_state_t state_q, state_d;
	logic pass2_q, pass2_d;

	always_comb begin
		state_d = state_q;
		pass2_d = pass2_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire && in_last) begin
					state_d = ST_CLR;
					pass2_d = 1'b0;
				end
			end
			ST_CLR:
				state_d = pass2_q ? ST_P2_ROOT : ST_P1_ROOT;
			ST_P1_ROOT: begin
				if (sts.root_done) begin
					state_d = ST_CLR;
					pass2_d = 1'b1;
				end else if (!sts.root_visited) begin
					state_d = ST_SCAN;
				end
			end
			ST_P2_ROOT: begin
				if (sts.fin_empty)
					state_d = ST_OUT_RD;
				else if (sts.p2_take)
					state_d = ST_SCAN;
				else
					state_d = ST_P2_WAIT;
			end
			ST_P2_WAIT:
				state_d = ST_P2_ROOT;
			ST_SCAN: begin
				if (sts.scan_done)
					state_d = ST_POP;
			end
			ST_POP: begin
				if (sts.stack_empty)
					state_d = pass2_q ? ST_P2_ROOT : ST_P1_ROOT;
				else
					state_d = ST_SCAN;
			end
			ST_OUT_RD: begin
				if (out_free)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_fire)
					state_d = sts.out_last ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.pass2 = pass2_q;
		in_rdy = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_rdy = 1'b1;
				cmd.store_edge = in_fire;
				cmd.out_start = 1'b1;
			end
			ST_CLR: cmd.clr_start = 1'b1;
			ST_P1_ROOT: begin
				if (!sts.root_done && !sts.root_visited)
					cmd.root_start = 1'b1;
				else if (!sts.root_done)
					cmd.clr_step = 1'b1;
			end
			ST_P2_ROOT: begin
				if (!sts.fin_empty && sts.p2_take)
					cmd.p2_start = 1'b1;
				else if (!sts.fin_empty)
					cmd.p2_pop = 1'b1;
			end
			ST_P2_WAIT: ;
			ST_SCAN: begin
				if (!sts.scan_done)
					cmd.scan_step = 1'b1;
			end
			ST_POP: begin
				if (!sts.stack_empty)
					cmd.pop_step = 1'b1;
			end
			ST_OUT_RD: begin
				if (out_free) begin
					cmd.out_rd = 1'b1;
					res_load = 1'b1;
				end
			end
			ST_OUT: begin
				if (out_fire) begin
					cmd.out_next = 1'b1;
					cmd.run_done = sts.out_last;
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_LOAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass2_q <= pass2_d;
		end
	end

	property p_no_in_busy;
		@(posedge clk) disable iff (!arst_n) busy |-> !in_rdy;
	endproperty
	a_no_in_busy: assert property (p_no_in_busy) else $error("input taken while busy");

	property p_last_start;
		@(posedge clk) disable iff (!arst_n) (in_fire && in_last) |=> state_q == ST_CLR;
	endproperty
	a_last_start: assert property (p_last_start) else $error("run did not start");

	property p_out_only;
		@(posedge clk) disable iff (!arst_n) res_load |-> state_q == ST_OUT_RD;
	endproperty
	a_out_only: assert property (p_out_only) else $error("result loaded outside output");

endmodule

// File: rtl/core/strongly_connected_components.sv
// Top level: edge loading, Kosaraju component labeling and per-node result output.
//  channel | direction | words
//  cfg     | in        | node_count write
//  in      | in        | one edge per word, last_edge starts a run
//  out     | out       | one result per node after a run
// Edges are taken one per cycle while in_ready is high; it stays low during a run. After the
// last word each pass scans every stored edge for every node that it searches.
// A finish-stack entry that is already reached is popped and skipped in the second pass.
// A result loads only once the last one is taken; output stalls hold the result register.
// Reset clears all control state and sets node_count to 64; no clearing pass is needed.
module strongly_connected_components import scc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CountW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              edge_valid,
	input  logic [NodeW-1:0]  edge_from,
	input  logic [NodeW-1:0]  edge_to,
	input  logic              last_edge,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NodeW-1:0]  node_index,
	output logic [CountW-1:0] component_id,
	output logic [CountW-1:0] component_total,
	output logic              edge_overflow,
	output logic              last_result
);

	scc_cmd_t cmd;
	scc_sts_t sts;
	logic [CountW-1:0] cnt_q;
	logic [CountW-1:0] n_eff;
	logic in_fire, out_fire, busy, res_load, ovalid_q;

	assign cfg_ready = 1'b1;
	assign n_eff = (cnt_q == '0) ? CountW'(1)
		: (cnt_q > CountW'(MaxNodes)) ? CountW'(MaxNodes) : cnt_q;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= CountW'(MaxNodes);
		else if (cfg_valid && cfg_ready)
			cnt_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (res_load)
			ovalid_q <= 1'b1;
		else if (out_fire)
			ovalid_q <= 1'b0;
	end

	scc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(last_edge),
		.out_free(!ovalid_q), .out_fire(out_fire), .sts(sts), .cmd(cmd),
		.in_rdy(in_ready), .busy(busy), .res_load(res_load)
	);

	scc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .n_eff(n_eff),
		.in_valid(edge_valid), .in_from(edge_from), .in_to(edge_to),
		.res_node(node_index), .res_id(component_id), .res_total(component_total),
		.res_ovf(edge_overflow), .res_last(last_result)
	);

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n) (out_valid && !out_ready) |=> out_valid;
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result word dropped");

	property p_busy_idle_in;
		@(posedge clk) disable iff (!arst_n) out_valid |-> busy;
	endproperty
	a_busy_idle_in: assert property (p_busy_idle_in) else $error("output while idle");

	property p_neff;
		@(posedge clk) disable iff (!arst_n) n_eff != '0;
	endproperty
	a_neff: assert property (p_neff) else $error("node count zero");

endmodule
